// File: design/motor_command_frame_parser_core_defines.svh
// Assertion helpers used by the parser RTL
`ifndef MOTOR_COMMAND_FRAME_PARSER_CORE_DEFINES_SVH
`define MOTOR_COMMAND_FRAME_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define MCFP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define MCFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/mcfp_pkg.sv
package mcfp_pkg;

  // Reset values of the configuration registers
  localparam logic [7:0] SyncByteRst   = 8'd33;
  localparam logic [7:0] CmdKeyRst     = 8'd65;
  localparam logic [7:0] MaxColumnRst  = 8'd2;

  // Default geometry of the motor array
  localparam int unsigned RowsDflt         = 3;
  localparam int unsigned MotorsPerRowDflt = 2;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgSyncByte  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCmdKey    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxColumn = 2'd2;

  // Result kinds
  localparam logic KindStep = 1'b0;
  localparam logic KindNack = 1'b1;

  // Nack error codes
  typedef enum logic [2:0] {
    NackBadKey    = 3'd0,
    NackBadColumn = 3'd1,
    NackBadRow    = 3'd2,
    NackBadMotor  = 3'd3,
    NackBadDir    = 3'd4
  } nack_code_e;

  // Received byte held in the input register
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } rx_item_t;

endpackage

// File: design/mcfp_in_stage.sv
module mcfp_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        rx_byte_i,
  input  logic              advance_i,
  output mcfp_pkg::rx_item_t item_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       load;

  // Take a new item when empty or when the held one moves on
  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the byte payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= rx_byte_i;
    end
  end

  assign item_o.valid = valid_q;
  assign item_o.data  = data_q;

endmodule

// File: design/mcfp_parser.sv
`include "motor_command_frame_parser_core_defines.svh"

module mcfp_parser #(
  parameter int unsigned ROWS           = mcfp_pkg::RowsDflt,
  parameter int unsigned MOTORS_PER_ROW = mcfp_pkg::MotorsPerRowDflt
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mcfp_pkg::rx_item_t             item_i,
  output logic                           advance_o,
  input  logic                           cfg_valid_i,
  input  logic [mcfp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [7:0]                     cfg_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           out_kind_o,
  output logic [2:0]                     nack_code_o,
  output logic [7:0]                     column_index_o,
  output logic [1:0]                     row_index_o,
  output logic                           motor_index_o,
  output logic [1:0]                     direction_code_o,
  output logic [15:0]                    step_count_o
);

  typedef enum logic [2:0] {
    PhSync   = 3'd0,
    PhKey    = 3'd1,
    PhColumn = 3'd2,
    PhRow    = 3'd3,
    PhMotor  = 3'd4,
    PhDir    = 3'd5,
    PhCntHi  = 3'd6,
    PhCntLo  = 3'd7
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] sync_q, key_q, maxcol_q;
  logic [7:0] col_q, col_d;
  logic [1:0] row_q, row_d;
  logic       motor_q, motor_d;
  logic       dir_q, dir_d;
  logic [7:0] cnthi_q, cnthi_d;

  logic       out_valid_q;
  logic       emit;
  logic       res_kind;
  mcfp_pkg::nack_code_e res_code;
  logic       res_load;
  logic [7:0] c;

  assign c = item_i.data;

  // Move the held byte on once the result register has room
  assign advance_o = item_i.valid && (!out_valid_q || out_ready_i);
  assign res_load  = advance_o && emit;

  // Frame parser step for one byte
  always_comb begin
    phase_d  = phase_q;
    col_d    = col_q;
    row_d    = row_q;
    motor_d  = motor_q;
    dir_d    = dir_q;
    cnthi_d  = cnthi_q;
    emit     = 1'b0;
    res_kind = mcfp_pkg::KindNack;
    res_code = mcfp_pkg::NackBadKey;
    unique case (phase_q)
      PhSync: begin
        if (c == sync_q) phase_d = PhKey;
      end
      PhKey: begin
        if (c != key_q) begin
          emit     = 1'b1;
          res_code = mcfp_pkg::NackBadKey;
          phase_d  = PhSync;
        end else begin
          phase_d = PhColumn;
        end
      end
      PhColumn: begin
        if (c > maxcol_q) begin
          emit     = 1'b1;
          res_code = mcfp_pkg::NackBadColumn;
          phase_d  = PhSync;
        end else begin
          col_d   = c;
          phase_d = PhRow;
        end
      end
      PhRow: begin
        if (c >= 8'(ROWS)) begin
          emit     = 1'b1;
          res_code = mcfp_pkg::NackBadRow;
          phase_d  = PhSync;
        end else begin
          row_d   = c[1:0];
          phase_d = PhMotor;
        end
      end
      PhMotor: begin
        if (c >= 8'(MOTORS_PER_ROW)) begin
          emit     = 1'b1;
          res_code = mcfp_pkg::NackBadMotor;
          phase_d  = PhSync;
        end else begin
          motor_d = c[0];
          phase_d = PhDir;
        end
      end
      PhDir: begin
        if (c > 8'd1) begin
          emit     = 1'b1;
          res_code = mcfp_pkg::NackBadDir;
          phase_d  = PhSync;
        end else begin
          dir_d   = c[0];
          phase_d = PhCntHi;
        end
      end
      PhCntHi: begin
        cnthi_d = c;
        phase_d = PhCntLo;
      end
      PhCntLo: begin
        emit     = 1'b1;
        res_kind = mcfp_pkg::KindStep;
        phase_d  = PhSync;
      end
      default: begin
        phase_d = PhSync;
      end
    endcase
  end

  // Hold parser state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhSync;
      sync_q   <= mcfp_pkg::SyncByteRst;
      key_q    <= mcfp_pkg::CmdKeyRst;
      maxcol_q <= mcfp_pkg::MaxColumnRst;
      col_q    <= '0;
      row_q    <= '0;
      motor_q  <= 1'b0;
      dir_q    <= 1'b0;
      cnthi_q  <= '0;
    end else begin
      if (advance_o) begin
        phase_q <= phase_d;
        col_q   <= col_d;
        row_q   <= row_d;
        motor_q <= motor_d;
        dir_q   <= dir_d;
        cnthi_q <= cnthi_d;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          mcfp_pkg::CfgSyncByte:  sync_q   <= cfg_data_i;
          mcfp_pkg::CfgCmdKey:    key_q    <= cfg_data_i;
          mcfp_pkg::CfgMaxColumn: maxcol_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Result valid: set on a new result, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload; nack zeroes the command fields
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_kind_o  <= res_kind;
      nack_code_o <= (res_kind == mcfp_pkg::KindNack) ? res_code : 3'd0;
      if (res_kind == mcfp_pkg::KindStep) begin
        column_index_o   <= col_q;
        row_index_o      <= row_q;
        motor_index_o    <= motor_q;
        direction_code_o <= {1'b0, dir_q} + 2'd1;
        step_count_o     <= {cnthi_q, c};
      end else begin
        column_index_o   <= '0;
        row_index_o      <= '0;
        motor_index_o    <= 1'b0;
        direction_code_o <= '0;
        step_count_o     <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  `MCFP_ASSERT_NEXT(a_sync_after_result, res_load, phase_q == PhSync,
                    "parser did not return to sync hunting after a result")
  `MCFP_ASSERT_IMPLY(a_step_dir_range,
                     out_valid_q && (out_kind_o == mcfp_pkg::KindStep),
                     (direction_code_o == 2'd1) || (direction_code_o == 2'd2),
                     "step command with direction code out of range")
  `MCFP_ASSERT_IMPLY(a_no_overwrite, out_valid_q && !out_ready_i, !res_load,
                     "result register overwritten while stalled")

endmodule

// File: design/motor_command_frame_parser_core.sv
// Path: an accepted byte is held in the input register, and its result is then loaded into the result register.
// Throughput: one byte per cycle while the output is not stalled.
// Output stalls back up through the input register to in_ready_o.
// Reset: parser hunts for sync, config returns to sync 33, key 65, max column 2.
module motor_command_frame_parser_core #(
  parameter int unsigned ROWS           = mcfp_pkg::RowsDflt,
  parameter int unsigned MOTORS_PER_ROW = mcfp_pkg::MotorsPerRowDflt
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   rx_byte_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [mcfp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                   cfg_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         out_kind_o,
  output logic [2:0]                   nack_code_o,
  output logic [7:0]                   column_index_o,
  output logic [1:0]                   row_index_o,
  output logic                         motor_index_o,
  output logic [1:0]                   direction_code_o,
  output logic [15:0]                  step_count_o
);

  mcfp_pkg::rx_item_t item;
  logic               advance;

  // Register writes never stall
  assign cfg_ready_o = 1'b1;

  mcfp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .rx_byte_i  (rx_byte_i),
    .advance_i  (advance),
    .item_o     (item)
  );

  mcfp_parser #(
    .ROWS           (ROWS),
    .MOTORS_PER_ROW (MOTORS_PER_ROW)
  ) u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_i           (item),
    .advance_o        (advance),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_kind_o       (out_kind_o),
    .nack_code_o      (nack_code_o),
    .column_index_o   (column_index_o),
    .row_index_o      (row_index_o),
    .motor_index_o    (motor_index_o),
    .direction_code_o (direction_code_o),
    .step_count_o     (step_count_o)
  );

endmodule
